// ===== design/flpr_pkg.sv =====
// ============================================================================
// flpr_pkg: shared constants and coefficient table for the low-pass FIR
// Holds the default parameter values, the fixed index width and the Q1.15
// tap table, with a helper that rescales a tap to the chosen coefficient width.
// ============================================================================
package flpr_pkg;

    localparam int TAP_COUNT_DEF      = 30;
    localparam int RESIDUAL_DELAY_DEF = 15;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_WIDTH_DEF     = 16;

    // Width of the running sample index field.
    localparam int IDX_W = 16;

    localparam int TABLE_TAPS = 30;

    localparam int LP_COEF_Q15 [TABLE_TAPS] = '{
        162, 184, 250, 356, 498, 669, 863, 1069, 1278, 1480,
        1666, 1826, 1954, 2043, 2088, 2088, 2043, 1954, 1826, 1666,
        1480, 1278, 1069, 863, 669, 498, 356, 250, 184, 162
    };

    // Tap k scaled to cw bits; taps beyond the table are zero. Narrower
    // widths round half up.
    function automatic int coef_at(input int k, input int cw);
        int c;
        int sh;
        c  = 0;
        sh = 0;
        if (k < 0 || k >= TABLE_TAPS) begin
            return 0;
        end
        c = LP_COEF_Q15[k];
        if (cw >= 16) begin
            return c <<< (cw - 16);
        end
        sh = 16 - cw;
        return (c + ((1 << sh) >>> 1)) >>> sh;
    endfunction

endpackage

// ===== design/fir_lowpass_with_residual.sv =====
// ============================================================================
// fir_lowpass_with_residual: symmetric low-pass FIR with delayed residual
// One shared multiply-accumulate walks a rotating tap line; the ring slot is
// found by a bit-serial remainder over the sample index.
// ============================================================================
// Usage
//   Input channel (s_axis): one item per sample, tdata holds the signed
//   sample and its running index. Output channel (m_axis): one item per input
//   item, tdata holds the saturated filtered value and the residual, tuser
//   carries the residual valid flag.
//   Each item is taken in the idle state; the tap line then rotates past the
//   one multiplier once per tap while the index remainder is formed one bit
//   per cycle, then a drain state empties the product register and a final
//   state rounds, saturates and loads the output register. The next input
//   item is accepted only once that final state has loaded its result.
//   The output register holds a finished item while the next input item is
//   taken and filtered; if that second result is ready before the first has
//   been taken, the block waits with it until the receiver takes the first.
//   Reset clears the tap line, the control state and the output valid flag.
//   The residual history ring is not cleared; its slots are written from
//   index TAP_COUNT on and read from index TAP_COUNT + RESIDUAL_DELAY on.
// ============================================================================
module fir_lowpass_with_residual #(
    parameter int TAP_COUNT      = flpr_pkg::TAP_COUNT_DEF,
    parameter int RESIDUAL_DELAY = flpr_pkg::RESIDUAL_DELAY_DEF,
    parameter int SAMPLE_WIDTH   = flpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = flpr_pkg::COEF_WIDTH_DEF,
    localparam int IN_W  = ((SAMPLE_WIDTH + flpr_pkg::IDX_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0: sample, sample_index, zero padding.
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // Fields from bit 0: filtered, residual, zero padding.
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: residual_valid.
    output logic [0:0]       o_m_axis_tuser
);

    localparam int IDX_W    = flpr_pkg::IDX_W;
    localparam int PROD_W   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
    localparam int LOOP     = (TAP_COUNT > IDX_W) ? TAP_COUNT : IDX_W;
    localparam int CNT_W    = $clog2(LOOP + 1);
    localparam int SLOT_W   = (RESIDUAL_DELAY > 1) ? $clog2(RESIDUAL_DELAY) : 1;
    localparam int RES_W    = SAMPLE_WIDTH + 1;
    localparam int PAD_W    = OUT_W - SAMPLE_WIDTH - RES_W;

    localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W + 1)'(1) <<< (COEF_WIDTH - 2);
    localparam logic signed [ACC_W:0] SAT_HI =
        (ACC_W + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W + 1)'(1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic signed [SAMPLE_WIDTH-1:0] r_line [TAP_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [IDX_W-1:0]               r_idx_sh;
    logic [SLOT_W-1:0]              r_rem;
    logic                           r_in_ring;
    logic                           r_res_on;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_prod_vld;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_hist [RESIDUAL_DELAY];
    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_filt;
    logic signed [RES_W-1:0]        r_out_res;
    logic                           r_out_rvld;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_mac_on;
    logic                           w_rem_on;
    logic signed [COEF_WIDTH-1:0]   w_coef;
    logic [SLOT_W:0]                w_rem2;
    logic [SLOT_W:0]                w_rem_next;
    logic signed [SAMPLE_WIDTH-1:0] w_in_sample;
    logic [IDX_W-1:0]               w_in_idx;
    logic signed [ACC_W:0]          w_biased;
    logic signed [ACC_W:0]          w_q;
    logic signed [SAMPLE_WIDTH-1:0] w_filt;
    logic signed [RES_W-1:0]        w_res;

    assign w_in_sample = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_in_idx    = i_s_axis_tdata[SAMPLE_WIDTH +: IDX_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;

    assign w_mac_on = (r_cnt < CNT_W'(TAP_COUNT));
    assign w_rem_on = (r_cnt < CNT_W'(IDX_W));
    assign w_coef   = COEF_WIDTH'(flpr_pkg::coef_at(int'(r_cnt), COEF_WIDTH));

    // Restoring remainder step, index bits taken most significant first.
    always_comb begin
        w_rem2     = {r_rem, r_idx_sh[IDX_W-1]};
        w_rem_next = w_rem2;
        if (w_rem2 >= (SLOT_W + 1)'(RESIDUAL_DELAY)) begin
            w_rem_next = w_rem2 - (SLOT_W + 1)'(RESIDUAL_DELAY);
        end
    end

    // Round half up by flooring after adding half an LSB, then saturate.
    always_comb begin
        w_biased = (ACC_W + 1)'(r_acc) + HALF_LSB;
        w_q      = w_biased >>> (COEF_WIDTH - 1);
        if (w_q > SAT_HI) begin
            w_filt = SAMPLE_WIDTH'(SAT_HI);
        end else if (w_q < SAT_LO) begin
            w_filt = SAMPLE_WIDTH'(SAT_LO);
        end else begin
            w_filt = SAMPLE_WIDTH'(w_q);
        end
        w_res = RES_W'(r_x) - RES_W'(r_hist[r_rem]);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_W'(LOOP - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_cnt      <= '0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // A new result may replace the one being taken in the same cycle.
            if (r_state == ST_FIN && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        // The new sample enters at the head; the tail entry
                        // falls out of the filter.
                        r_line[0] <= w_in_sample;
                        for (int i = 1; i < TAP_COUNT; i++) begin
                            r_line[i] <= r_line[i-1];
                        end
                        r_x        <= w_in_sample;
                        r_idx_sh   <= w_in_idx;
                        r_rem      <= '0;
                        r_in_ring  <= (w_in_idx >= IDX_W'(TAP_COUNT));
                        r_res_on   <= (w_in_idx >= IDX_W'(TAP_COUNT + RESIDUAL_DELAY));
                        r_cnt      <= '0;
                        r_acc      <= '0;
                        r_prod_vld <= 1'b0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_prod_vld) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    r_prod_vld <= w_mac_on;
                    if (w_mac_on) begin
                        r_prod <= w_coef * r_line[0];
                        // One full turn of the line leaves it as it was.
                        r_line[TAP_COUNT-1] <= r_line[0];
                        for (int i = 0; i < TAP_COUNT - 1; i++) begin
                            r_line[i] <= r_line[i+1];
                        end
                    end
                    if (w_rem_on) begin
                        r_rem    <= SLOT_W'(w_rem_next);
                        r_idx_sh <= {r_idx_sh[IDX_W-2:0], 1'b0};
                    end
                end
                ST_DRAIN: begin
                    if (r_prod_vld) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    r_prod_vld <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload of the output register and the history ring.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_filt <= w_filt;
            r_out_res  <= r_res_on ? w_res : '0;
            r_out_rvld <= r_res_on;
            if (r_in_ring) begin
                r_hist[r_rem] <= w_filt;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out_res, r_out_filt};
    assign o_m_axis_tuser  = r_out_rvld;

endmodule
